// ----- hdl/cpc_pkg.sv -----
package cpc_pkg;

  localparam int TIMER_WIDTH = 8;
  localparam int CHANNELS    = 4;
  localparam int CH_W        = 2;
  localparam int COUNT_W     = 27;
  localparam int TOTAL_W     = 31;
  localparam int SUM_W       = 32;
  localparam int HOLDOFF_W   = 8;
  localparam int STEP_W      = 8;
  localparam int LIMIT_W     = 47;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 47;
  localparam int WEIGHT_W    = 5;
  localparam int HOLD_CMP_W  = (TIMER_WIDTH + 1 > HOLDOFF_W) ? TIMER_WIDTH + 1 : HOLDOFF_W;

  localparam logic [COUNT_W-1:0]     CNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0]     TOT_MAX = {TOTAL_W{1'b1}};
  localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_ONE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TWO  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_FIVE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF_TEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_STEP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LIMIT  = 3'd6;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_ONE_RESET  = 8'd70;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_TWO_RESET  = 8'd150;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_FIVE_RESET = 8'd70;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_TEN_RESET  = 8'd70;
  localparam logic [STEP_W-1:0]    FULL_STEP_RESET    = 8'd33;
  localparam logic [COUNT_W-1:0]   COUNT_LIMIT_RESET  = 27'd9999999;
  localparam logic [LIMIT_W-1:0]   TOTAL_LIMIT_RESET  = 47'd99999999999999;

  localparam logic [CHANNELS-1:0][WEIGHT_W-1:0] COIN_WEIGHT = {5'd10, 5'd5, 5'd2, 5'd1};

  typedef struct packed {
    logic [3:0] sensor_levels;
    logic       counting_enable;
    logic       clear_counts;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_one;
    logic [COUNT_W-1:0] count_two;
    logic [COUNT_W-1:0] count_five;
    logic [COUNT_W-1:0] count_ten;
    logic [TOTAL_W-1:0] weighted_total;
    logic [3:0]         counted_mask;
    logic               full_alert;
    logic [CH_W-1:0]    full_channel;
    logic               limit_halted;
  } out_t;

  typedef struct packed {
    logic                 fire;
    logic                 clear;
    logic                 active;
    logic                 grant;
    logic                 level;
    logic [HOLDOFF_W-1:0] holdoff;
    logic [STEP_W-1:0]    step_size;
  } lane_ctrl_t;

  typedef struct packed {
    logic               counted;
    logic               incremented;
    logic               at_threshold;
    logic [COUNT_W-1:0] count;
  } lane_status_t;

endpackage

// ----- hdl/cpc_lane.sv -----
module cpc_lane import cpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  lane_ctrl_t   ctrl,
  output lane_status_t status
);

  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_next;
  logic                   locked;
  logic                   locked_next;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  logic [COUNT_W-1:0]     threshold;
  logic [COUNT_W-1:0]     threshold_next;
  logic [TIMER_WIDTH:0]   elapsed;
  logic [COUNT_W:0]       thr_sum;
  logic                   can_count;
  logic                   inc;
  logic                   release_lock;

  always_comb begin
    can_count    = ctrl.active & ctrl.level & ~locked;
    inc          = can_count & (count != CNT_MAX);
    elapsed      = {1'b0, timer} + {{TIMER_WIDTH{1'b0}}, 1'b1};
    release_lock = ctrl.active & ~ctrl.level & locked &
                   (HOLD_CMP_W'(elapsed) > HOLD_CMP_W'(ctrl.holdoff));

    if (ctrl.clear) begin
      count_next = '0;
    end else begin
      count_next = count + COUNT_W'(inc);
    end

    if (ctrl.clear) begin
      locked_next = 1'b0;
    end else if (can_count) begin
      locked_next = 1'b1;
    end else if (release_lock) begin
      locked_next = 1'b0;
    end else begin
      locked_next = locked;
    end

    // ticks since the count, held once the channel is released
    if (ctrl.clear || can_count) begin
      timer_next = '0;
    end else if (locked_next) begin
      timer_next = elapsed[TIMER_WIDTH] ? TMR_MAX : elapsed[TIMER_WIDTH-1:0];
    end else begin
      timer_next = timer;
    end

    thr_sum = {1'b0, threshold} + (COUNT_W + 1)'(ctrl.step_size);
    if (ctrl.clear) begin
      threshold_next = COUNT_W'(ctrl.step_size);
    end else if (ctrl.grant) begin
      threshold_next = thr_sum[COUNT_W] ? CNT_MAX : thr_sum[COUNT_W-1:0];
    end else begin
      threshold_next = threshold;
    end

    status.counted      = can_count;
    status.incremented  = inc;
    status.count        = count_next;
    status.at_threshold = ~ctrl.clear & (count_next >= threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      locked    <= 1'b0;
      timer     <= '0;
      threshold <= COUNT_W'(FULL_STEP_RESET);
    end else if (ctrl.fire) begin
      count     <= count_next;
      locked    <= locked_next;
      timer     <= timer_next;
      threshold <= threshold_next;
    end
  end

endmodule

// ----- hdl/cpc_merge.sv -----
module cpc_merge import cpc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  in_t                         item,
  input  logic [COUNT_W-1:0]          count_limit,
  input  logic [LIMIT_W-1:0]          total_limit,
  input  lane_status_t [CHANNELS-1:0] lanes,
  input  logic                        out_stall,
  output logic                        active,
  output logic [CHANNELS-1:0]         grant,
  output logic                        out_valid,
  output out_t                        out_data
);

  logic [SUM_W-1:0]    total;
  logic [SUM_W-1:0]    total_next;
  logic [TOTAL_W-1:0]  total_sat;
  logic                halted;
  logic                halted_next;
  logic [WEIGHT_W-1:0] delta;
  logic                limit_hit;
  logic [CH_W-1:0]     alert_ch;
  logic                alert;
  logic [3:0]          mask;
  out_t                result;

  always_comb begin
    active = item.counting_enable & ~halted & ~item.clear_counts;

    // weight of the coins that really advanced a count this transfer
    delta     = '0;
    limit_hit = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lanes[i].incremented) begin
        delta = delta + COIN_WEIGHT[i];
      end
      if (lanes[i].count >= count_limit) begin
        limit_hit = 1'b1;
      end
      mask[i] = lanes[i].counted;
    end

    total_next = item.clear_counts ? '0 : total + SUM_W'(delta);
    total_sat  = total_next[SUM_W-1] ? TOT_MAX : total_next[TOTAL_W-1:0];
    if (LIMIT_W'(total_sat) >= total_limit) begin
      limit_hit = 1'b1;
    end

    if (item.clear_counts) begin
      halted_next = 1'b0;
    end else begin
      halted_next = halted | (active & limit_hit);
    end

    // lowest channel wins the alert
    grant    = '0;
    alert    = 1'b0;
    alert_ch = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (lanes[i].at_threshold) begin
        alert    = 1'b1;
        alert_ch = CH_W'(i);
      end
    end
    if (alert) begin
      grant[alert_ch] = 1'b1;
    end

    result.count_one      = lanes[0].count;
    result.count_two      = lanes[1].count;
    result.count_five     = lanes[2].count;
    result.count_ten      = lanes[3].count;
    result.weighted_total = total_sat;
    result.counted_mask   = mask;
    result.full_alert     = alert;
    result.full_channel   = alert_ch;
    result.limit_halted   = halted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        total     <= total_next;
        halted    <= halted_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  // the halt only drops on a clear transfer
  assert property (@(posedge clk) disable iff (rst)
    $fell(halted) |-> $past(fire && item.clear_counts))
    else $error("halt dropped without a clear");

  // the running sum only grows between clears
  assert property (@(posedge clk) disable iff (rst)
    (fire && !item.clear_counts) |=> (total >= $past(total)))
    else $error("weighted sum went down");

  // nothing counts while halted
  assert property (@(posedge clk) disable iff (rst)
    (fire && halted && !item.clear_counts) |=> (out_data.counted_mask == '0))
    else $error("coin counted while halted");

  // at most one threshold advances per transfer
  assert property (@(posedge clk) disable iff (rst)
    fire |-> $onehot0(grant))
    else $error("more than one bin alert granted");

  // a clear transfer goes out with no alert and a zero weighted sum
  assert property (@(posedge clk) disable iff (rst)
    (fire && item.clear_counts) |=> (!out_data.full_alert && out_data.weighted_total == '0))
    else $error("clear transfer did not show cleared state");

endmodule

// ----- hdl/coin_pulse_counter.sv -----
// a result is registered on its input transfer and shows in the cycle after it
// throughput: one sensor tick per cycle while in_stall is low; the four channel
// lanes and the merge of their counts, weighted sum and limit checks are combinational
// input stalls in reset and while a finished result is held back by out_stall
// reset (synchronous, rst high): counts, locks, timers, sum and halt cleared,
// registers back to their defaults, no result pending
module coin_pulse_counter import cpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CHANNELS-1:0][HOLDOFF_W-1:0] holdoff;
  logic [STEP_W-1:0]                  full_step;
  logic [COUNT_W-1:0]                 count_limit;
  logic [LIMIT_W-1:0]                 total_limit;
  logic [STEP_W-1:0]                  step_size;
  logic                               fire;
  logic                               active;
  logic [CHANNELS-1:0]                grant;
  lane_ctrl_t   [CHANNELS-1:0]        lane_ctrl;
  lane_status_t [CHANNELS-1:0]        lane_status;

  assign in_stall  = rst | (out_valid & out_stall);
  assign fire      = in_valid & ~in_stall;
  // a zero step behaves as one
  assign step_size = (full_step == '0) ? STEP_W'(1) : full_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff[0]  <= HOLDOFF_ONE_RESET;
      holdoff[1]  <= HOLDOFF_TWO_RESET;
      holdoff[2]  <= HOLDOFF_FIVE_RESET;
      holdoff[3]  <= HOLDOFF_TEN_RESET;
      full_step   <= FULL_STEP_RESET;
      count_limit <= COUNT_LIMIT_RESET;
      total_limit <= TOTAL_LIMIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HOLDOFF_ONE:  holdoff[0]  <= cfg_data[HOLDOFF_W-1:0];
        REG_HOLDOFF_TWO:  holdoff[1]  <= cfg_data[HOLDOFF_W-1:0];
        REG_HOLDOFF_FIVE: holdoff[2]  <= cfg_data[HOLDOFF_W-1:0];
        REG_HOLDOFF_TEN:  holdoff[3]  <= cfg_data[HOLDOFF_W-1:0];
        REG_FULL_STEP:    full_step   <= cfg_data[STEP_W-1:0];
        REG_COUNT_LIMIT:  count_limit <= cfg_data[COUNT_W-1:0];
        REG_TOTAL_LIMIT:  total_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    always_comb begin
      lane_ctrl[i].fire      = fire;
      lane_ctrl[i].clear     = in_data.clear_counts;
      lane_ctrl[i].active    = active;
      lane_ctrl[i].grant     = grant[i];
      lane_ctrl[i].level     = in_data.sensor_levels[i];
      lane_ctrl[i].holdoff   = holdoff[i];
      lane_ctrl[i].step_size = step_size;
    end

    cpc_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl[i]),
      .status (lane_status[i])
    );
  end

  cpc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (in_data),
    .count_limit (count_limit),
    .total_limit (total_limit),
    .lanes       (lane_status),
    .out_stall   (out_stall),
    .active      (active),
    .grant       (grant),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
